@@ design/positional_list_engine_top_defines.svh @@
// assertion macros for the positional list engine
// used by the top level; expects i_clk and i_rst_n in scope
`ifndef POSITIONAL_LIST_ENGINE_TOP_DEFINES_SVH
`define POSITIONAL_LIST_ENGINE_TOP_DEFINES_SVH

// condition implies consequence in the same cycle
`define PLE_ASSERT_NOW(label, cond, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (cons)) \
        else $error(msg);

// condition implies consequence in the next cycle
`define PLE_ASSERT_NEXT(label, cond, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

@@ design/ple_pkg.sv @@
// shared types and codes for the positional list engine
// no dependencies
`timescale 1ns / 1ps

package ple_pkg;

    // request kinds
    typedef enum logic [2:0] {
        KIND_INS_FRONT = 3'd0,
        KIND_INS_END   = 3'd1,
        KIND_INS_AT    = 3'd2,
        KIND_DEL_FRONT = 3'd3,
        KIND_DEL_END   = 3'd4,
        KIND_DEL_AT    = 3'd5,
        KIND_READ_ALL  = 3'd6
    } t_kind;

    // result status codes
    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2,
        STAT_POS   = 2'd3
    } t_status;

    // what every cell of the chain does this cycle
    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_DELETE = 2'd2,
        CELL_ROTATE = 2'd3
    } t_cell_op;

    typedef struct packed {
        t_cell_op           op;
        logic signed [31:0] value;
    } t_cell_ctl;

endpackage

@@ design/ple_cell.sv @@
// one storage cell of the list chain
// depends on ple_pkg for the control struct
`timescale 1ns / 1ps

module ple_cell #(
    parameter int CAPACITY = 16,
    parameter int INDEX    = 0
) (
    input  logic                            i_clk,
    input  ple_pkg::t_cell_ctl              i_ctl,
    input  logic [$clog2(CAPACITY)-1:0]     i_slot,
    input  logic [$clog2(CAPACITY)-1:0]     i_tail,
    input  logic signed [31:0]              i_left,
    input  logic signed [31:0]              i_right,
    input  logic signed [31:0]              i_first,
    output logic signed [31:0]              o_data
);

    localparam int IW = $clog2(CAPACITY);
    localparam logic [IW-1:0] MY_INDEX = IW'(INDEX);

    logic signed [31:0] r_data;
    logic signed [31:0] n_data;

    // pick this cell's next value from its neighbors, the insert value or cell 0
    always_comb begin
        n_data = r_data;
        unique case (i_ctl.op)
            ple_pkg::CELL_HOLD: begin
                n_data = r_data;
            end
            ple_pkg::CELL_INSERT: begin
                if (MY_INDEX > i_slot) begin
                    n_data = i_left;
                end else if (MY_INDEX == i_slot) begin
                    n_data = i_ctl.value;
                end
            end
            ple_pkg::CELL_DELETE: begin
                if (MY_INDEX >= i_slot) begin
                    n_data = i_right;
                end
            end
            ple_pkg::CELL_ROTATE: begin
                if (MY_INDEX == i_tail) begin
                    n_data = i_first;
                end else if (MY_INDEX < i_tail) begin
                    n_data = i_right;
                end
            end
            default: n_data = r_data;
        endcase
    end

    // payload register, no reset
    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

@@ design/positional_list_engine_top.sv @@
// Positional list engine: an ordered list of up to CAPACITY signed 32-bit values
// held in a chain of cells that all shift toward or away from a slot together.
// An insert or delete is accepted and its single result appears in the output
// register in the next cycle; a new item is accepted whenever the output
// register is empty or being taken, so inserts and deletes run at one item per
// cycle. A read-all emits one result per element held (one result with status
// empty for an empty list): the chain rotates one position per cycle while the
// output register is empty or being taken, and cell 0 feeds the output. No item
// is accepted until the last result of a read-all is loaded. The store needs no
// clearing pass after reset; only elements below the length are ever read.
// depends on ple_pkg, ple_cell and positional_list_engine_top_defines.svh
`timescale 1ns / 1ps

`include "positional_list_engine_top_defines.svh"

module positional_list_engine_top #(
    parameter int CAPACITY = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [2:0]         i_kind,
    input  logic [4:0]         i_position,
    input  logic signed [31:0] i_value,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [1:0]         o_status,
    output logic signed [31:0] o_data,
    output logic [4:0]         o_count,
    output logic               o_last
);

    localparam int IW = $clog2(CAPACITY);
    localparam int LW = $clog2(CAPACITY + 1);
    localparam int CW = ((LW > 5) ? LW : 5) + 1;
    localparam logic [LW-1:0] FULL_LEN = LW'(CAPACITY);

    typedef enum logic {
        ST_IDLE,
        ST_READ
    } t_state;

    t_state             r_state, n_state;
    logic [LW-1:0]      r_len, n_len;
    logic [IW-1:0]      r_rd_cnt, n_rd_cnt;
    logic               r_out_valid, n_out_valid;
    ple_pkg::t_status   r_status, n_status;
    logic signed [31:0] r_data, n_data;
    logic [LW-1:0]      r_count, n_count;
    logic               r_last, n_last;

    ple_pkg::t_cell_ctl w_ctl;
    logic [IW-1:0]      w_slot;
    logic [IW-1:0]      w_tail;
    logic signed [31:0] w_cell [CAPACITY];

    logic               w_take;
    logic               w_acc;
    logic               w_full;
    logic               w_empty;
    logic [CW-1:0]      w_pos;
    logic [CW-1:0]      w_len;
    logic [IW-1:0]      w_pos_slot;
    logic               w_do_ins;

    // handshake
    assign w_take     = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == ST_IDLE) && w_take;
    assign w_acc      = i_in_valid && o_in_ready;

    assign w_full     = (r_len == FULL_LEN);
    assign w_empty    = (r_len == '0);
    assign w_pos      = CW'(i_position);
    assign w_len      = CW'(r_len);
    assign w_pos_slot = IW'(w_pos - CW'(1));
    assign w_tail     = IW'(r_len - LW'(1));

    // chain of cells
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [31:0] w_left;
        logic signed [31:0] w_right;
        if (g == 0) begin : g_head
            assign w_left = w_cell[g];
        end else begin : g_mid_l
            assign w_left = w_cell[g-1];
        end
        if (g == CAPACITY - 1) begin : g_end
            assign w_right = w_cell[g];
        end else begin : g_mid_r
            assign w_right = w_cell[g+1];
        end
        ple_cell #(
            .CAPACITY (CAPACITY),
            .INDEX    (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_slot  (w_slot),
            .i_tail  (w_tail),
            .i_left  (w_left),
            .i_right (w_right),
            .i_first (w_cell[0]),
            .o_data  (w_cell[g])
        );
    end

    // request decode and read-all sequencing
    always_comb begin
        n_state     = r_state;
        n_len       = r_len;
        n_rd_cnt    = r_rd_cnt;
        n_out_valid = r_out_valid && !i_out_ready;
        n_status    = r_status;
        n_data      = r_data;
        n_count     = r_count;
        n_last      = r_last;
        w_ctl.op    = ple_pkg::CELL_HOLD;
        w_ctl.value = i_value;
        w_slot      = '0;
        w_do_ins    = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_acc) begin
                    n_data  = '0;
                    n_count = r_len;
                    n_last  = 1'b1;
                    unique case (ple_pkg::t_kind'(i_kind))
                        ple_pkg::KIND_INS_FRONT,
                        ple_pkg::KIND_INS_END,
                        ple_pkg::KIND_INS_AT: begin
                            n_out_valid = 1'b1;
                            if (w_full) begin
                                n_status = ple_pkg::STAT_FULL;
                            end else if (ple_pkg::t_kind'(i_kind) == ple_pkg::KIND_INS_AT &&
                                         (w_pos == '0 || w_pos > w_len + CW'(1))) begin
                                n_status = ple_pkg::STAT_POS;
                            end else begin
                                w_do_ins = 1'b1;
                                n_status = ple_pkg::STAT_OK;
                                w_ctl.op = ple_pkg::CELL_INSERT;
                                if (ple_pkg::t_kind'(i_kind) == ple_pkg::KIND_INS_FRONT) begin
                                    w_slot = '0;
                                end else if (ple_pkg::t_kind'(i_kind) ==
                                             ple_pkg::KIND_INS_END) begin
                                    w_slot = IW'(r_len);
                                end else begin
                                    w_slot = w_pos_slot;
                                end
                                n_len   = r_len + LW'(1);
                                n_count = r_len + LW'(1);
                            end
                        end
                        ple_pkg::KIND_DEL_FRONT,
                        ple_pkg::KIND_DEL_END,
                        ple_pkg::KIND_DEL_AT: begin
                            n_out_valid = 1'b1;
                            if (w_empty) begin
                                n_status = ple_pkg::STAT_EMPTY;
                            end else if (ple_pkg::t_kind'(i_kind) == ple_pkg::KIND_DEL_AT &&
                                         (w_pos == '0 || w_pos > w_len)) begin
                                n_status = ple_pkg::STAT_POS;
                            end else begin
                                n_status = ple_pkg::STAT_OK;
                                w_ctl.op = ple_pkg::CELL_DELETE;
                                if (ple_pkg::t_kind'(i_kind) == ple_pkg::KIND_DEL_FRONT) begin
                                    w_slot = '0;
                                end else if (ple_pkg::t_kind'(i_kind) ==
                                             ple_pkg::KIND_DEL_END) begin
                                    w_slot = w_tail;
                                end else begin
                                    w_slot = w_pos_slot;
                                end
                                n_data  = w_cell[w_slot];
                                n_len   = r_len - LW'(1);
                                n_count = r_len - LW'(1);
                            end
                        end
                        ple_pkg::KIND_READ_ALL: begin
                            if (w_empty) begin
                                n_out_valid = 1'b1;
                                n_status    = ple_pkg::STAT_EMPTY;
                            end else begin
                                n_state  = ST_READ;
                                n_rd_cnt = '0;
                            end
                        end
                        default: begin
                            // unused kind: no result
                        end
                    endcase
                end
            end
            ST_READ: begin
                if (w_take) begin
                    w_ctl.op    = ple_pkg::CELL_ROTATE;
                    n_out_valid = 1'b1;
                    n_status    = ple_pkg::STAT_OK;
                    n_data      = w_cell[0];
                    n_count     = r_len;
                    n_last      = (r_rd_cnt == w_tail);
                    n_rd_cnt    = r_rd_cnt + IW'(1);
                    if (r_rd_cnt == w_tail) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_len       <= '0;
            r_rd_cnt    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_len       <= n_len;
            r_rd_cnt    <= n_rd_cnt;
            r_out_valid <= n_out_valid;
        end
        r_status <= n_status;
        r_data   <= n_data;
        r_count  <= n_count;
        r_last   <= n_last;
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_data      = r_data;
    assign o_count     = 5'(r_count);
    assign o_last      = r_last;

    // checks on the engine's own bookkeeping
    `PLE_ASSERT_NOW(a_len_bound, 1'b1, r_len <= FULL_LEN, "length above capacity")
    `PLE_ASSERT_NOW(a_read_blocks, r_state == ST_READ, !o_in_ready, "item taken during read-all")
    `PLE_ASSERT_NEXT(a_ins_grows, w_acc && w_do_ins, r_len == LW'($past(r_len) + LW'(1)), "insert did not grow list")

endmodule

@@ tb/sv/tb_positional_list_engine_top.sv @@
// self-checking testbench for positional_list_engine_top
// keeps its own copy of the list, predicts every result and checks each one in order
// depends on ple_pkg and the positional list engine rtl
`timescale 1ns / 1ps

module tb_positional_list_engine_top;
    import ple_pkg::*;

    localparam int CAPACITY      = 16;
    localparam int IDLE_LIMIT    = 2000;
    localparam int DRAIN_CYCLES  = 20;
    localparam int HOLD_OFF_LONG = 200;
    localparam logic [2:0] KIND_UNUSED = 3'd7;

    typedef struct {
        t_status            status;
        logic signed [31:0] data;
        logic [4:0]         count;
        logic               last;
    } t_list_result;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic [2:0]         i_kind = 3'd0;
    logic [4:0]         i_position = 5'd0;
    logic signed [31:0] i_value = 32'sd0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic [1:0]         o_status;
    logic signed [31:0] o_data;
    logic [4:0]         o_count;
    logic               o_last;

    // shadow copy of the list held by the block
    logic signed [31:0] shadow_list [CAPACITY];
    int                 shadow_len = 0;
    t_list_result       pending_results [$];

    int  fail_count = 0;
    int  idle_cycles = 0;
    bit  sender_gaps = 1'b0;
    bit  receiver_stalls = 1'b0;
    int  hold_off_request = 0;
    int  stall_left = 0;

    positional_list_engine_top #(
        .CAPACITY(CAPACITY)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_kind(i_kind),
        .i_position(i_position),
        .i_value(i_value),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_status(o_status),
        .o_data(o_data),
        .o_count(o_count),
        .o_last(o_last)
    );

    always #5 i_clk = ~i_clk;

    // idle length: mostly none or short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return 32'sh0000_0000;
            3: return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    // mostly a legal position up to hi, sometimes anything the field holds
    function automatic logic [4:0] pick_position(input int hi);
        if ($urandom_range(0, 4) == 0 || hi < 1) return 5'($urandom_range(0, 31));
        return 5'($urandom_range(1, hi));
    endfunction

    task automatic push_result(input t_status st, input logic signed [31:0] d, input logic lst);
        t_list_result r;
        r.status = st;
        r.data   = d;
        r.count  = shadow_len[4:0];
        r.last   = lst;
        pending_results.push_back(r);
    endtask

    // apply one request to the shadow list and queue the results it causes
    task automatic predict_request(input logic [2:0] kind, input logic [4:0] pos,
                                   input logic signed [31:0] val);
        int slot;
        logic signed [31:0] taken;
        case (kind)
            KIND_INS_FRONT, KIND_INS_END, KIND_INS_AT: begin
                if (shadow_len >= CAPACITY) begin
                    push_result(STAT_FULL, 32'sd0, 1'b1);
                end else if (kind == KIND_INS_AT && (pos == 0 || int'(pos) > shadow_len + 1)) begin
                    push_result(STAT_POS, 32'sd0, 1'b1);
                end else begin
                    if (kind == KIND_INS_FRONT) slot = 0;
                    else if (kind == KIND_INS_END) slot = shadow_len;
                    else slot = int'(pos) - 1;
                    for (int i = shadow_len; i > slot; i--)
                        shadow_list[i] = shadow_list[i-1];
                    shadow_list[slot] = val;
                    shadow_len++;
                    push_result(STAT_OK, 32'sd0, 1'b1);
                end
            end
            KIND_DEL_FRONT, KIND_DEL_END, KIND_DEL_AT: begin
                if (shadow_len == 0) begin
                    push_result(STAT_EMPTY, 32'sd0, 1'b1);
                end else if (kind == KIND_DEL_AT && (pos == 0 || int'(pos) > shadow_len)) begin
                    push_result(STAT_POS, 32'sd0, 1'b1);
                end else begin
                    if (kind == KIND_DEL_FRONT) slot = 0;
                    else if (kind == KIND_DEL_END) slot = shadow_len - 1;
                    else slot = int'(pos) - 1;
                    taken = shadow_list[slot];
                    for (int i = slot; i + 1 < shadow_len; i++)
                        shadow_list[i] = shadow_list[i+1];
                    shadow_len--;
                    push_result(STAT_OK, taken, 1'b1);
                end
            end
            KIND_READ_ALL: begin
                if (shadow_len == 0) begin
                    push_result(STAT_EMPTY, 32'sd0, 1'b1);
                end else begin
                    for (int i = 0; i < shadow_len; i++)
                        push_result(STAT_OK, shadow_list[i], i == shadow_len - 1);
                end
            end
            default: begin
                // unused kind: nothing comes back
            end
        endcase
    endtask

    // offer one item and wait until the block takes it
    task automatic send_request(input logic [2:0] kind, input logic [4:0] pos,
                                input logic signed [31:0] val);
        int gap;
        gap = sender_gaps ? pick_gap() : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_kind     <= kind;
        i_position <= pos;
        i_value    <= val;
        do @(posedge i_clk); while (!(i_in_valid && o_in_ready));
        predict_request(kind, pos, val);
    endtask

    // random request shaped by the current length
    task automatic send_random_request();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) begin
            case ($urandom_range(0, 2))
                0: send_request(KIND_INS_FRONT, 5'($urandom), pick_value());
                1: send_request(KIND_INS_END, 5'($urandom), pick_value());
                default: send_request(KIND_INS_AT, pick_position(shadow_len + 1), pick_value());
            endcase
        end else if (r < 85) begin
            case ($urandom_range(0, 2))
                0: send_request(KIND_DEL_FRONT, 5'($urandom), $urandom);
                1: send_request(KIND_DEL_END, 5'($urandom), $urandom);
                default: send_request(KIND_DEL_AT, pick_position(shadow_len), $urandom);
            endcase
        end else if (r < 96) begin
            send_request(KIND_READ_ALL, 5'($urandom), $urandom);
        end else begin
            send_request(KIND_UNUSED, 5'($urandom), $urandom);
        end
    endtask

    // requests on an empty list, error precedence and the unused kind
    task automatic test_empty_list();
        send_request(KIND_READ_ALL, 5'd0, 32'sd0);
        send_request(KIND_DEL_FRONT, 5'd1, 32'sd0);
        send_request(KIND_DEL_END, 5'd1, 32'sd0);
        send_request(KIND_DEL_AT, 5'd0, 32'sd0);
        send_request(KIND_INS_AT, 5'd0, 32'sd5);
        send_request(KIND_INS_AT, 5'd2, 32'sd5);
        send_request(KIND_UNUSED, 5'd31, -32'sd1);
    endtask

    // value extremes, append via insert-at, bad positions, single element delete
    task automatic test_edges();
        send_request(KIND_INS_AT, 5'd1, 32'sh8000_0000);
        send_request(KIND_DEL_END, 5'd0, 32'sd0);
        send_request(KIND_INS_END, 5'd0, 32'sh7fff_ffff);
        send_request(KIND_INS_FRONT, 5'd0, 32'sd0);
        send_request(KIND_INS_AT, 5'd3, -32'sd1);
        send_request(KIND_INS_AT, 5'd2, 32'sh5555_5555);
        send_request(KIND_INS_AT, 5'd1, 32'shaaaa_aaaa);
        send_request(KIND_DEL_AT, 5'd0, 32'sd0);
        send_request(KIND_DEL_AT, 5'd6, 32'sd0);
        send_request(KIND_DEL_AT, 5'd31, 32'sd0);
        send_request(KIND_INS_AT, 5'd31, 32'sd7);
        send_request(KIND_READ_ALL, 5'd0, 32'sd0);
        send_request(KIND_DEL_AT, 5'd2, 32'sd0);
        send_request(KIND_DEL_FRONT, 5'd0, 32'sd0);
        send_request(KIND_DEL_END, 5'd0, 32'sd0);
        send_request(KIND_READ_ALL, 5'd0, 32'sd0);
    endtask

    // fill to capacity, hit the full cases, read everything, drain to empty, hit the empty cases
    task automatic test_fill_and_drain();
        while (shadow_len < CAPACITY) begin
            case ($urandom_range(0, 2))
                0: send_request(KIND_INS_FRONT, 5'($urandom), pick_value());
                1: send_request(KIND_INS_END, 5'($urandom), pick_value());
                default: send_request(KIND_INS_AT, 5'($urandom_range(1, shadow_len + 1)),
                                      pick_value());
            endcase
        end
        send_request(KIND_INS_FRONT, 5'd1, 32'sd1);
        send_request(KIND_INS_END, 5'd1, 32'sd2);
        send_request(KIND_INS_AT, 5'd0, 32'sd3);
        send_request(KIND_READ_ALL, 5'd0, 32'sd0);
        while (shadow_len > 0) begin
            case ($urandom_range(0, 2))
                0: send_request(KIND_DEL_FRONT, 5'($urandom), $urandom);
                1: send_request(KIND_DEL_END, 5'($urandom), $urandom);
                default: send_request(KIND_DEL_AT, 5'($urandom_range(1, shadow_len)), $urandom);
            endcase
        end
        send_request(KIND_DEL_AT, 5'd1, 32'sd0);
        send_request(KIND_READ_ALL, 5'd0, 32'sd0);
    endtask

    // receiver holds off for a long stretch while items keep coming
    task automatic test_backpressure(input int n);
        sender_gaps      = 1'b0;
        hold_off_request = HOLD_OFF_LONG;
        repeat (n) send_random_request();
    endtask

    task automatic test_random_mix(input int n, input bit gaps_in, input bit stalls_out);
        sender_gaps     = gaps_in;
        receiver_stalls = stalls_out;
        repeat (n) send_random_request();
    endtask

    // receiver: random stalls, long hold-off on request
    always @(posedge i_clk) begin
        if (hold_off_request != 0) begin
            stall_left       = hold_off_request;
            hold_off_request = 0;
        end
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else if (receiver_stalls && $urandom_range(0, 99) < 25) begin
            stall_left = pick_gap();
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // result checker and watchdog
    always @(posedge i_clk) begin
        t_list_result want;
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (o_out_valid && i_out_ready) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: result with nothing expected: status %0d data %0d",
                             $time, o_status, o_data);
                    fail_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (o_status !== want.status) begin
                        $display("%0t: status expected %0d actual %0d", $time, want.status,
                                 o_status);
                        fail_count++;
                    end
                    if (o_data !== want.data) begin
                        $display("%0t: data expected %0d actual %0d", $time, want.data, o_data);
                        fail_count++;
                    end
                    if (o_count !== want.count) begin
                        $display("%0t: count expected %0d actual %0d", $time, want.count,
                                 o_count);
                        fail_count++;
                    end
                    if (o_last !== want.last) begin
                        $display("%0t: last expected %0d actual %0d", $time, want.last, o_last);
                        fail_count++;
                    end
                end
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // test sequence
    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_list();
        test_edges();
        sender_gaps = 1'b1;
        receiver_stalls = 1'b1;
        test_fill_and_drain();
        test_random_mix(80, 1'b0, 1'b0);
        test_random_mix(160, 1'b1, 1'b1);
        test_backpressure(40);
        test_random_mix(40, 1'b1, 1'b0);
        test_random_mix(40, 1'b0, 1'b1);
        test_fill_and_drain();
        i_in_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
